// ===== hdl/bsle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared types and constants for the bounded shift list engine.
// ----------------------------------------------------------------------------
package bsle_pkg;

	localparam int DEPTH   = 16;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int FOUND_W = IDX_W + 1;
	localparam int OP_W    = 3;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 3;

	// s_tdata: value, position; padded to whole bytes
	localparam int S_DATA_BITS = WORD_W + POS_W;
	localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
	// m_tdata: found_index, read_data, fill_count, list_empty
	localparam int M_DATA_BITS = FOUND_W + WORD_W + CNT_W + 1;
	localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_PREPEND = 3'd1,
		OP_DROP    = 3'd2,
		OP_DELETE  = 3'd3,
		OP_REMOVE  = 3'd4,
		OP_FIND    = 3'd5,
		OP_READ    = 3'd6
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	localparam logic signed [FOUND_W-1:0] NO_INDEX = '1;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_APPEND,
		CMD_PREPEND,
		CMD_CLOSE
	} cmd_kind_t;

	// command broadcast to every cell in the row
	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] at;
		word_t            value;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/bsle_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_cell
// One list slot: holds one word, loads it from the input or a neighbor.
// ----------------------------------------------------------------------------
module bsle_cell (
	input  wire                          clk,
	input  wire logic [bsle_pkg::IDX_W-1:0] idx,
	input  bsle_pkg::cell_cmd_t          cmd,
	input  bsle_pkg::word_t              left,
	input  bsle_pkg::word_t              right,
	output bsle_pkg::word_t              entry,
	output logic                         match
);
	import bsle_pkg::*;

	word_t entry_q;

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_APPEND: begin
				if (idx == cmd.at) begin
					entry_q <= cmd.value;
				end
			end
			CMD_PREPEND: begin
				entry_q <= (idx == '0) ? cmd.value : left;
			end
			CMD_CLOSE: begin
				// slots at and above the gap take their right neighbor
				if (idx >= cmd.at) begin
					entry_q <= right;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	assign match = (entry_q == cmd.value);

endmodule
`default_nettype wire

// ===== hdl/bsle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_ctrl
// Decodes each word, keeps the fill count, drives the cell row and holds
// the result register.
// ----------------------------------------------------------------------------
module bsle_ctrl (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire logic [bsle_pkg::OP_W-1:0]  opcode,
	input  bsle_pkg::word_t                 value,
	input  wire logic [bsle_pkg::POS_W-1:0] position,
	input  bsle_pkg::word_t                 entries [bsle_pkg::DEPTH],
	input  wire logic [bsle_pkg::DEPTH-1:0] eq_flags,
	output bsle_pkg::cell_cmd_t             cmd,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [bsle_pkg::STAT_W-1:0]     status,
	output logic signed [bsle_pkg::FOUND_W-1:0] found_index,
	output bsle_pkg::word_t                 read_data,
	output logic [bsle_pkg::CNT_W-1:0]      fill_count,
	output logic                            list_empty
);
	import bsle_pkg::*;

	logic [CNT_W-1:0]           count_q;
	logic                       out_valid_q;
	status_t                    status_q;
	logic signed [FOUND_W-1:0]  found_q;
	word_t                      data_q;

	logic                       accept;
	logic [DEPTH-1:0]           hits;
	logic                       any_hit;
	logic [IDX_W-1:0]           hit_idx;
	logic [CNT_W-1:0]           pos_ext;
	logic                       is_full;
	logic                       no_entries;
	logic                       pos_ok;

	status_t                    status_d;
	logic signed [FOUND_W-1:0]  found_d;
	word_t                      data_d;
	logic [CNT_W-1:0]           count_d;
	cell_cmd_t                  cmd_d;

	assign in_ready   = !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign pos_ext    = CNT_W'(position);
	assign is_full    = (count_q == CNT_W'(DEPTH));
	assign no_entries = (count_q == '0);
	assign pos_ok     = (pos_ext < count_q);

	// only slots below the fill count take part in a search
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hits[i] = eq_flags[i] && (CNT_W'(i) < count_q);
		end
	end

	// lowest matching slot wins
	always_comb begin
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign any_hit = |hits;

	always_comb begin
		status_d    = ST_OK;
		found_d     = NO_INDEX;
		data_d      = '0;
		count_d     = count_q;
		cmd_d.kind  = CMD_HOLD;
		cmd_d.at    = '0;
		cmd_d.value = value;
		case (opcode_t'(opcode))
			OP_APPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					cmd_d.kind = CMD_APPEND;
					cmd_d.at   = count_q[IDX_W-1:0];
					count_d    = count_q + 1'b1;
				end
			end
			OP_PREPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					cmd_d.kind = CMD_PREPEND;
					count_d    = count_q + 1'b1;
				end
			end
			OP_DROP: begin
				if (no_entries) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			OP_DELETE: begin
				if (no_entries) begin
					status_d = ST_EMPTY;
				end else if (!pos_ok) begin
					status_d = ST_RANGE;
				end else begin
					cmd_d.kind = CMD_CLOSE;
					cmd_d.at   = pos_ext[IDX_W-1:0];
					count_d    = count_q - 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!any_hit) begin
					status_d = ST_NOTFOUND;
				end else begin
					found_d    = FOUND_W'(hit_idx);
					cmd_d.kind = CMD_CLOSE;
					cmd_d.at   = hit_idx;
					count_d    = count_q - 1'b1;
				end
			end
			OP_FIND: begin
				if (!any_hit) begin
					status_d = ST_NOTFOUND;
				end else begin
					found_d = FOUND_W'(hit_idx);
				end
			end
			OP_READ: begin
				if (no_entries) begin
					status_d = ST_EMPTY;
				end else if (!pos_ok) begin
					status_d = ST_RANGE;
				end else begin
					data_d = entries[pos_ext[IDX_W-1:0]];
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		if (!accept) begin
			cmd_d.kind = CMD_HOLD;
		end
	end

	assign cmd = cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			found_q  <= found_d;
			data_q   <= data_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign read_data   = data_q;
	assign fill_count  = count_q;
	assign list_empty  = (count_q == '0);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
			count_q == $past(count_q) - 1'b1))
		else $error("fill count moved by more than one");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("fill count changed without a word");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q != NO_INDEX) |-> status_q == ST_OK)
		else $error("found index with a failing status");

endmodule
`default_nettype wire

// ===== hdl/bounded_shift_list_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_shift_list_engine_top
// Ordered list of signed words in a row of shifting cells.
// ----------------------------------------------------------------------------
// Every word on the slave side gives one result word on the master side. All
// cells shift and compare against the input at once, so one word per clock
// is sustained while the result register is drained, and the result is
// registered and appears in the cycle after acceptance. The fill count and
// status travel with every result; entries at or above the fill count are
// never read.
module bounded_shift_list_engine_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [31:0] value, [35:32] position, upper bits zero
	input  wire  [39:0] s_tdata,
	// [2:0] opcode
	input  wire  [2:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [4:0] found_index, [36:5] read_data, [41:37] fill_count, [42] list_empty
	output logic [47:0] m_tdata,
	// [2:0] status
	output logic [2:0]  m_tuser
);
	import bsle_pkg::*;

	word_t                     entries [DEPTH];
	logic [DEPTH-1:0]          eq_flags;
	cell_cmd_t                 cmd;
	logic [STAT_W-1:0]         status;
	logic signed [FOUND_W-1:0] found_index;
	word_t                     read_data;
	logic [CNT_W-1:0]          fill_count;
	logic                      list_empty;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entries[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entries[g+1];
		end
		bsle_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.entry (entries[g]),
			.match (eq_flags[g])
		);
	end

	bsle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.opcode      (s_tuser[OP_W-1:0]),
		.value       (s_tdata[WORD_W-1:0]),
		.position    (s_tdata[WORD_W +: POS_W]),
		.entries     (entries),
		.eq_flags    (eq_flags),
		.cmd         (cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.status      (status),
		.found_index (found_index),
		.read_data   (read_data),
		.fill_count  (fill_count),
		.list_empty  (list_empty)
	);

	assign m_tuser = status;
	assign m_tdata = {{(M_DATA_W - M_DATA_BITS){1'b0}}, list_empty, fill_count,
		read_data, found_index};

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded shift list engine: every accepted word
// is run through a local list model and the result word is compared field by
// field, under random gaps, long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
module testbench;

	import bsle_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;
	localparam int              CYCLE_LIMIT = 1500000;
	localparam int              RANDOM_ITEMS = 1880;

	typedef struct {
		status_t              status;
		logic [FOUND_W-1:0]   found;
		word_t                data;
		logic [CNT_W-1:0]     fill;
		logic                 empty;
	} list_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [39:0]         s_tdata;
	logic [2:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [47:0]         m_tdata;
	logic [2:0]          m_tuser;

	// list model state
	word_t               list_mem [DEPTH];
	int                  list_len;

	list_result_t        expected_results [$];
	int                  fail_count;
	int                  cycle_count;
	bit                  tx_idle_en;
	bit                  rx_idle_en;
	int                  rx_hold_left;
	int                  rx_stall_left;

	bounded_shift_list_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[bounded_shift_list_engine_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// list model
	// ------------------------------------------------------------------
	function automatic int first_index(word_t v);
		for (int i = 0; i < list_len; i++)
			if (list_mem[i] == v)
				return i;
		return -1;
	endfunction

	function automatic void close_gap(int at);
		for (int i = at; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endfunction

	function automatic list_result_t apply_list_op(logic [2:0] op, word_t v, logic [3:0] pos);
		list_result_t res;
		int           hit;
		res.status = ST_OK;
		res.found  = NO_INDEX;
		res.data   = '0;
		case (op)
			OP_APPEND: begin
				if (list_len >= DEPTH)
					res.status = ST_FULL;
				else begin
					list_mem[list_len] = v;
					list_len++;
				end
			end
			OP_PREPEND: begin
				if (list_len >= DEPTH)
					res.status = ST_FULL;
				else begin
					for (int i = list_len; i > 0; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[0] = v;
					list_len++;
				end
			end
			OP_DROP: begin
				if (list_len == 0)
					res.status = ST_EMPTY;
				else
					list_len--;
			end
			OP_DELETE: begin
				if (list_len == 0)
					res.status = ST_EMPTY;
				else if (int'(pos) >= list_len)
					res.status = ST_RANGE;
				else
					close_gap(int'(pos));
			end
			OP_REMOVE: begin
				hit = first_index(v);
				if (hit < 0)
					res.status = ST_NOTFOUND;
				else begin
					res.found = hit[FOUND_W-1:0];
					close_gap(hit);
				end
			end
			OP_FIND: begin
				hit = first_index(v);
				if (hit < 0)
					res.status = ST_NOTFOUND;
				else
					res.found = hit[FOUND_W-1:0];
			end
			OP_READ: begin
				if (list_len == 0)
					res.status = ST_EMPTY;
				else if (int'(pos) >= list_len)
					res.status = ST_RANGE;
				else
					res.data = list_mem[pos];
			end
			default: ;
		endcase
		res.fill  = list_len[CNT_W-1:0];
		res.empty = (list_len == 0);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(logic [2:0] op, word_t v, logic [3:0] pos);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, pos, v};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		expected_results.push_back(apply_list_op(op, v, pos));
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic word_t pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (list_len > 0 && r < 45)
			return list_mem[$urandom_range(0, list_len - 1)];
		else if (r < 65) begin
			case ($urandom_range(0, 5))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return -32'sd1;
				3: return 32'sd0;
				default: return word_t'($urandom_range(1, 4));
			endcase
		end
		return word_t'($urandom);
	endfunction

	function automatic logic [3:0] pick_position();
		if (list_len > 0 && $urandom_range(0, 3) != 0)
			return 4'($urandom_range(0, list_len - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic send_random_item(bit grow);
		int         r;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		if (grow)
			op = r < 30 ? OP_APPEND : r < 55 ? OP_PREPEND : r < 61 ? OP_DROP :
				r < 68 ? OP_DELETE : r < 76 ? OP_REMOVE : r < 86 ? OP_FIND :
				r < 98 ? OP_READ : OP_UNUSED;
		else
			op = r < 10 ? OP_APPEND : r < 18 ? OP_PREPEND : r < 33 ? OP_DROP :
				r < 48 ? OP_DELETE : r < 63 ? OP_REMOVE : r < 78 ? OP_FIND :
				r < 98 ? OP_READ : OP_UNUSED;
		send_word(op, pick_value(), pick_position());
	endtask

	// ------------------------------------------------------------------
	// receiver and checker
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		list_result_t want;
		if (expected_results.size() == 0) begin
			$error("result word with no expectation waiting: %0h / %0h", m_tuser, m_tdata);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			check_field("status", 32'(want.status), 32'(m_tuser));
			check_field("found_index", 32'(want.found), 32'(m_tdata[4:0]));
			check_field("read_data", want.data, m_tdata[36:5]);
			check_field("fill_count", 32'(want.fill), 32'(m_tdata[41:37]));
			check_field("list_empty", 32'(want.empty), 32'(m_tdata[42]));
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid === 1'b1 && m_tready)
				check_result();
			if (rx_hold_left > 0) begin
				// long hold-off so the engine backs up into its input
				m_tready <= 1'b0;
				rx_hold_left--;
			end else if (rx_stall_left > 0) begin
				m_tready <= 1'b0;
				rx_stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en)
					rx_stall_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// operations on an empty list, including the unused opcode
		send_word(OP_DROP, 32'sd0, 4'd0);
		send_word(OP_DELETE, 32'sd0, 4'd0);
		send_word(OP_READ, 32'sd0, 4'd15);
		send_word(OP_FIND, 32'sd0, 4'd0);
		send_word(OP_UNUSED, -32'sd1, 4'd15);
		// fill to the top with extreme words, duplicates included
		send_word(OP_APPEND, 32'sh7FFF_FFFF, 4'd0);
		send_word(OP_PREPEND, 32'sh8000_0000, 4'd15);
		for (int i = 0; i < 14; i++)
			send_word(i[0] ? OP_PREPEND : OP_APPEND,
				i[1] ? 32'sh5555_5555 : 32'shAAAA_AAAA, 4'(i));
		// insert into a full list is refused
		send_word(OP_APPEND, -32'sd1, 4'd0);
		send_word(OP_PREPEND, 32'sd0, 4'd0);
		send_word(OP_READ, 32'sd0, 4'd15);
		send_word(OP_FIND, 32'sh5555_5555, 4'd0);
		send_word(OP_REMOVE, 32'sh7FFF_FFFF, 4'd0);
		// index beyond fill
		send_word(OP_READ, 32'sd0, 4'd15);
		send_word(OP_DELETE, 32'sd0, 4'd15);
		send_word(OP_DELETE, 32'sd0, 4'd0);
		send_word(OP_DROP, 32'sd0, 4'd0);
	endtask

	task automatic test_backpressure();
		tx_idle_en   = 1'b0;
		rx_hold_left = 150;
		for (int i = 0; i < 30; i++)
			send_random_item(list_len < 8);
		tx_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 20; i++) begin
			send_random_item(list_len < 8);
			if (i % 5 == 4) begin
				go_idle();
				wait (expected_results.size() == 0);
				@(posedge clk);
			end
		end
	endtask

	task automatic test_random();
		bit grow;
		grow = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				tx_idle_en = ($urandom_range(0, 4) != 0);
				rx_idle_en = ($urandom_range(0, 4) != 0);
			end
			// swing between filling up and draining so full and empty recur
			if (list_len == DEPTH)
				grow = 1'b0;
			else if (list_len == 0)
				grow = 1'b1;
			send_random_item(grow);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		list_len      = 0;
		fail_count    = 0;
		cycle_count   = 0;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		rx_hold_left  = 0;
		rx_stall_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random();
		go_idle();

		wait (expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[bounded_shift_list_engine_top] OK");
		else
			$display("[bounded_shift_list_engine_top] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bsle_pkg.sv
hdl/bsle_cell.sv
hdl/bsle_ctrl.sv
hdl/bounded_shift_list_engine_top.sv
sim/testbench.sv
